@@ hw/rtl/imm_pkg.sv @@
`default_nettype none

package imm_pkg;

	localparam int ELEM_W     = 16;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 35;
	localparam int IDX_W      = 3;
	localparam int DIM_W      = 4;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	localparam logic FUNC_LOAD_A = 1'b0;
	localparam logic FUNC_LOAD_B = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] inner;
		logic [DIM_W-1:0] cols;
	} dims_t;

	typedef struct packed {
		logic [PROD_W-1:0] product;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last;
	} result_t;

	typedef struct packed {
		logic run;
		logic busy;
	} mac_status_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] max_dim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > max_dim) begin
			r = max_dim;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/imm_ram.sv @@
`default_nettype none

module imm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/imm_mac.sv @@
`default_nettype none

module imm_mac #(
	parameter int AW = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire imm_pkg::dims_t              dims,
	output imm_pkg::mac_status_t             status,
	output logic                             rd_en,
	output logic [AW-1:0]                    a_raddr,
	output logic [AW-1:0]                    b_raddr,
	input  wire logic [imm_pkg::ELEM_W-1:0]  a_rdata,
	input  wire logic [imm_pkg::ELEM_W-1:0]  b_rdata,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output imm_pkg::result_t                 result
);

	import imm_pkg::*;

	logic              run_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic [AW-1:0]     row_base_q, a_addr_q, b_addr_q;
	logic              last_i, last_j, last_k;
	logic              issue, reserve, push, pop;

	logic              valid_s1, first_s1, last_s1, end_s1;
	logic [IDX_W-1:0]  row_s1, col_s1;
	logic              valid_s2, first_s2, last_s2, end_s2;
	logic [IDX_W-1:0]  row_s2, col_s2;
	logic signed [MUL_W-1:0]  prod_s2;
	logic signed [PROD_W-1:0] acc_q, acc_next;

	result_t           fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_PTR_W:0]   fill_q, cnt_q;

	assign last_i = DIM_W'(i_q) == dims.rows - DIM_W'(1);
	assign last_j = DIM_W'(j_q) == dims.cols - DIM_W'(1);
	assign last_k = DIM_W'(k_q) == dims.inner - DIM_W'(1);

	assign issue   = run_q && (k_q != '0 || cnt_q < (OUT_PTR_W + 1)'(OUT_DEPTH));
	assign reserve = issue && k_q == '0;
	assign pop     = out_valid && !out_stall;
	assign push    = valid_s2 && last_s2;

	assign rd_en   = issue;
	assign a_raddr = a_addr_q;
	assign b_raddr = b_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			row_base_q <= '0;
			a_addr_q   <= '0;
			b_addr_q   <= '0;
		end else if (start) begin
			run_q      <= 1'b1;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			row_base_q <= '0;
			a_addr_q   <= '0;
			b_addr_q   <= '0;
		end else if (issue) begin
			if (last_k) begin
				k_q <= '0;
				if (last_j) begin
					j_q      <= '0;
					b_addr_q <= '0;
					if (last_i) begin
						run_q <= 1'b0;
					end else begin
						i_q        <= i_q + IDX_W'(1);
						row_base_q <= row_base_q + AW'(dims.inner);
						a_addr_q   <= row_base_q + AW'(dims.inner);
					end
				end else begin
					j_q      <= j_q + IDX_W'(1);
					a_addr_q <= row_base_q;
					b_addr_q <= AW'(j_q) + AW'(1);
				end
			end else begin
				k_q      <= k_q + IDX_W'(1);
				a_addr_q <= a_addr_q + AW'(1);
				b_addr_q <= b_addr_q + AW'(dims.cols);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			end_s1   <= 1'b0;
			valid_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			end_s2   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			first_s1 <= k_q == '0;
			last_s1  <= last_k;
			end_s1   <= last_k && last_j && last_i;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			end_s2   <= end_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1  <= i_q;
		col_s1  <= j_q;
		row_s2  <= row_s1;
		col_s2  <= col_s1;
		prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
	end

	assign acc_next = first_s2 ? PROD_W'(prod_s2) : acc_q + PROD_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= acc_next;
		end
		if (push) begin
			fifo_q[wr_ptr_q] <= '{product: acc_next, row: row_s2, col: col_s2,
				last: end_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			fill_q <= fill_q + (OUT_PTR_W + 1)'(push) - (OUT_PTR_W + 1)'(pop);
			cnt_q  <= cnt_q + (OUT_PTR_W + 1)'(reserve) - (OUT_PTR_W + 1)'(pop);
		end
	end

	assign out_valid   = fill_q != '0;
	assign result      = fifo_q[rd_ptr_q];
	assign status.run  = run_q;
	assign status.busy = run_q || cnt_q != '0;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (OUT_PTR_W + 1)'(OUT_DEPTH))
		else $error("result slots over-reserved");

	a_fill_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cnt_q)
		else $error("more results queued than reserved");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fill_q < (OUT_PTR_W + 1)'(OUT_DEPTH) || pop))
		else $error("result queue overflow");

	a_run_ends_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last_k && last_j && last_i) |-> ##2 (push && end_s2))
		else $error("final product not marked");

endmodule

`default_nettype wire

@@ hw/rtl/integer_matrix_multiply.sv @@
// Integer matrix multiplier, P = A x B.
// Input words carry func and element. Elements of A (func low) and then of B
// (func high) are written in row-major order into two memories with one write
// port and one read port each, one word per cycle while in_stall is low. Words
// beyond a matrix's size are dropped.
// The word that completes B starts the product run; the input stalls for the
// whole run. One multiply-accumulate unit walks rows, columns and the inner
// index; each term passes the memory read register and the product register
// before it is added to the sum, and a finished sum is written into the queue.
// Product words leave through a four-entry queue in row-major order, the last
// one with last_out set. A stall on the output holds the queue; once all four
// entries are reserved, the accumulate unit waits before it starts a new word.
// Configuration writes are accepted only while no run and no result is
// pending. A write to a size register clears both load counters. A value of
// zero acts as one and a value above MAX_DIM acts as MAX_DIM.
// Reset sets all three sizes to eight and clears the counters and the queue.
// Memory contents are not cleared.
`default_nettype none

module integer_matrix_multiply #(
	parameter int MAX_DIM = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           func,
	input  wire logic [imm_pkg::ELEM_W-1:0]     element,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [imm_pkg::PROD_W-1:0]          product,
	output logic [imm_pkg::IDX_W-1:0]           out_row,
	output logic [imm_pkg::IDX_W-1:0]           out_col,
	output logic                                last_out,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [imm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [imm_pkg::DIM_W-1:0]      cfg_data
);

	import imm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DIM_W-1:0]  rows_q, inner_q, cols_q;
	logic [CNT_W-1:0]  count_a_q, count_b_q;
	logic [CNT_W-1:0]  size_a, size_b;
	dims_t             dims;
	mac_status_t       status;
	result_t           result;
	logic              cfg_wr, in_acc, load_a, load_b, b_done;
	logic              rd_en;
	logic [AW-1:0]     a_raddr, b_raddr;
	logic [ELEM_W-1:0] a_rdata, b_rdata;

	assign cfg_ready = !status.busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_stall  = status.run;
	assign in_acc    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			cols_q  <= DIM_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_ROWS_A:    rows_q  <= cfg_data;
				REG_INNER_LEN: inner_q <= cfg_data;
				REG_COLS_B:    cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dims.rows  = eff_dim(rows_q, DIM_W'(MAX_DIM));
	assign dims.inner = eff_dim(inner_q, DIM_W'(MAX_DIM));
	assign dims.cols  = eff_dim(cols_q, DIM_W'(MAX_DIM));

	assign size_a = CNT_W'(dims.rows) * CNT_W'(dims.inner);
	assign size_b = CNT_W'(dims.inner) * CNT_W'(dims.cols);

	assign load_a = in_acc && func == FUNC_LOAD_A && count_a_q < size_a;
	assign load_b = in_acc && func == FUNC_LOAD_B && count_b_q < size_b;
	assign b_done = load_b && count_b_q + CNT_W'(1) == size_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
		end else if (cfg_wr && cfg_index <= REG_COLS_B) begin
			count_a_q <= '0;
			count_b_q <= '0;
		end else if (b_done) begin
			count_a_q <= '0;
			count_b_q <= '0;
		end else begin
			if (load_a) begin
				count_a_q <= count_a_q + CNT_W'(1);
			end
			if (load_b) begin
				count_b_q <= count_b_q + CNT_W'(1);
			end
		end
	end

	imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (load_a),
		.waddr (count_a_q[AW-1:0]),
		.wdata (element),
		.re    (rd_en),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (load_b),
		.waddr (count_b_q[AW-1:0]),
		.wdata (element),
		.re    (rd_en),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	imm_mac #(.AW(AW)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (b_done),
		.dims      (dims),
		.status    (status),
		.rd_en     (rd_en),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.a_rdata   (a_rdata),
		.b_rdata   (b_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign product  = result.product;
	assign out_row  = result.row;
	assign out_col  = result.col;
	assign last_out = result.last;

endmodule

`default_nettype wire

@@ tb/sv/tb_integer_matrix_multiply.sv @@
module tb_integer_matrix_multiply;
	timeunit 1ns;
	timeprecision 1ps;

	import imm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int IDLE_LIMIT = 3000;
	localparam int CFG_SETTLE = 8;
	localparam int DRAIN_CYCLES = 20;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 func = FUNC_LOAD_A;
	logic [ELEM_W-1:0]    element = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PROD_W-1:0]    product;
	logic [IDX_W-1:0]     out_row;
	logic [IDX_W-1:0]     out_col;
	logic                 last_out;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS_A;
	logic [DIM_W-1:0]     cfg_data = '0;

	logic signed [ELEM_W-1:0] mat_a [64];
	logic signed [ELEM_W-1:0] mat_b [64];
	int unsigned fill_a = 0;
	int unsigned fill_b = 0;
	logic [DIM_W-1:0] rows_cfg = DIM_RESET;
	logic [DIM_W-1:0] inner_cfg = DIM_RESET;
	logic [DIM_W-1:0] cols_cfg = DIM_RESET;

	result_t products_due[$];
	int errors = 0;
	int words_taken = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 37;
	int recv_idle_pct = 84;

	integer_matrix_multiply u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.element   (element),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.product   (product),
		.out_row   (out_row),
		.out_col   (out_col),
		.last_out  (last_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int dim_used(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > 4'd8) begin
			return 8;
		end
		return int'(v);
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		if ($urandom_range(99) < 12) begin
			return DIM_W'($urandom_range(8, 15));
		end
		return DIM_W'($urandom_range(0, 4));
	endfunction

	function automatic logic [ELEM_W-1:0] pick_element();
		case ($urandom_range(7))
			0: begin
				return 16'h8000;
			end
			1: begin
				return 16'h7fff;
			end
			2: begin
				return $urandom_range(1) ? 16'hffff : 16'h0000;
			end
			default: begin
				return ELEM_W'($urandom);
			end
		endcase
	endfunction

	// Loads one word into the matrix stores and, when B is complete, queues the
	// whole product in row-major order.
	task automatic load_and_multiply(input logic f, input logic [ELEM_W-1:0] e,
		output bit taken);
		int r;
		int n;
		int c;
		longint acc;
		result_t res;
		r = dim_used(rows_cfg);
		n = dim_used(inner_cfg);
		c = dim_used(cols_cfg);
		taken = 1'b0;
		if (f == FUNC_LOAD_A) begin
			if (fill_a < r * n) begin
				mat_a[fill_a] = e;
				fill_a++;
				taken = 1'b1;
			end
		end else if (fill_b < n * c) begin
			mat_b[fill_b] = e;
			fill_b++;
			taken = 1'b1;
			if (fill_b == n * c) begin
				for (int i = 0; i < r; i++) begin
					for (int j = 0; j < c; j++) begin
						acc = 0;
						for (int k = 0; k < n; k++) begin
							acc += longint'(mat_a[i * n + k]) * longint'(mat_b[k * c + j]);
						end
						res.product = acc[PROD_W-1:0];
						res.row = IDX_W'(i);
						res.col = IDX_W'(j);
						res.last = (i == r - 1) && (j == c - 1);
						products_due.push_back(res);
					end
				end
				fill_a = 0;
				fill_b = 0;
			end
		end
	endtask

	task automatic send_word(input logic f, input logic [ELEM_W-1:0] e);
		bit taken;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		element <= e;
		do @(posedge clk); while (in_stall);
		load_and_multiply(f, e, taken);
		if (taken) begin
			words_taken++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		in_valid <= 1'b0;
		while (products_due.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ROWS_A: begin
				rows_cfg = data;
			end
			REG_INNER_LEN: begin
				inner_cfg = data;
			end
			REG_COLS_B: begin
				cols_cfg = data;
			end
			default: begin
				return;
			end
		endcase
		fill_a = 0;
		fill_b = 0;
	endtask

	// Full size at the reset dimensions. Every entry of A is written here, so no
	// later product can read an entry that was never loaded.
	task automatic test_reset_dims();
		for (int i = 0; i < 64; i++) begin
			send_word(FUNC_LOAD_A, 16'h8000);
		end
		for (int k = 0; k < 8; k++) begin
			for (int j = 0; j < 8; j++) begin
				send_word(FUNC_LOAD_B, j[0] ? 16'h7fff : 16'h8000);
			end
		end
	endtask

	// B alone completes the product, which then uses the A words left from before.
	task automatic test_stale_a();
		write_reg(REG_ROWS_A, 4'd2);
		write_reg(REG_INNER_LEN, 4'd2);
		write_reg(REG_COLS_B, 4'd2);
		send_word(FUNC_LOAD_B, 16'h0001);
		send_word(FUNC_LOAD_B, 16'hffff);
		send_word(FUNC_LOAD_B, 16'h0000);
		send_word(FUNC_LOAD_B, 16'h7fff);
	endtask

	// Zero sizes act as one and oversized ones as eight; a word beyond a full A
	// is dropped, and a write to an unused index changes nothing.
	task automatic test_degenerate_dims();
		logic [ELEM_W-1:0] b_words [8];
		b_words = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555,
			16'haaaa, 16'h8001};
		write_reg(REG_ROWS_A, 4'd0);
		write_reg(REG_INNER_LEN, 4'd0);
		write_reg(REG_COLS_B, 4'd15);
		write_reg(REG_NONE, 4'd15);
		send_word(FUNC_LOAD_A, 16'h7fff);
		send_word(FUNC_LOAD_A, 16'h1234);
		for (int i = 0; i < 8; i++) begin
			send_word(FUNC_LOAD_B, b_words[i]);
		end
	endtask

	task automatic test_random_runs(input int target);
		int start;
		int a_left;
		int b_left;
		logic f;
		start = words_taken;
		while (words_taken - start < target) begin
			if ($urandom_range(99) < 60) begin
				write_reg(REG_ROWS_A, pick_dim());
			end
			if ($urandom_range(99) < 60) begin
				write_reg(REG_INNER_LEN, pick_dim());
			end
			if ($urandom_range(99) < 60) begin
				write_reg(REG_COLS_B, pick_dim());
			end
			if ($urandom_range(99) < 5) begin
				write_reg(REG_NONE, DIM_W'($urandom_range(15)));
			end
			a_left = dim_used(rows_cfg) * dim_used(inner_cfg);
			b_left = dim_used(inner_cfg) * dim_used(cols_cfg);
			while (a_left + b_left > 0) begin
				if ($urandom_range(49) == 0) begin
					break;
				end
				if (a_left > 0 && b_left > 1 && $urandom_range(9) == 0) begin
					f = FUNC_LOAD_B;
					b_left--;
				end else if (a_left > 0) begin
					f = FUNC_LOAD_A;
					a_left--;
				end else if ($urandom_range(19) == 0) begin
					f = FUNC_LOAD_A;
				end else begin
					f = FUNC_LOAD_B;
					b_left--;
				end
				send_word(f, pick_element());
			end
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (products_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual product %0d row %0d col %0d",
					$time, $signed(product), out_row, out_col);
				errors++;
			end else begin
				want = products_due.pop_front();
				if (product !== want.product) begin
					$display("%0t: product expected %0d actual %0d", $time,
						$signed(want.product), $signed(product));
					errors++;
				end
				if (out_row !== want.row) begin
					$display("%0t: out_row expected %0d actual %0d", $time, want.row, out_row);
					errors++;
				end
				if (out_col !== want.col) begin
					$display("%0t: out_col expected %0d actual %0d", $time, want.col, out_col);
					errors++;
				end
				if (last_out !== want.last) begin
					$display("%0t: last_out expected %0b actual %0b", $time, want.last, last_out);
					errors++;
				end
			end
		end
		out_stall <= arst_n && recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_dims();
		test_stale_a();
		test_degenerate_dims();
		test_random_runs(15);
		send_idle_pct = 84;
		recv_idle_pct = 37;
		test_random_runs(20);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_runs(20);
		in_valid <= 1'b0;
		while (products_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ integer_matrix_multiply.f @@
hw/rtl/imm_pkg.sv
hw/rtl/imm_ram.sv
hw/rtl/imm_mac.sv
hw/rtl/integer_matrix_multiply.sv
tb/sv/tb_integer_matrix_multiply.sv
